>>> design/blen_pkg.sv
// shared types and codes for the bounded ordered list engine
package blen_pkg;

    localparam int MODE_W = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int ENT_W  = 5;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TRAVERSE  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [ENT_W-1:0]         entries;
        logic                     last;
    } blen_res_t;

endpackage

>>> design/blen_store.sv
// element store: one write port, one registered read port
module blen_store #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [blen_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [blen_pkg::DATA_W-1:0] rdata
);
    import blen_pkg::*;

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/blen_ctrl.sv
// sequencer: shifts, reads and compares list elements one at a time
module blen_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [blen_pkg::MODE_W-1:0]   in_mode,
    input  logic [blen_pkg::DATA_W-1:0]   in_value,
    input  logic [blen_pkg::POS_W-1:0]    in_position,
    output logic                          res_valid,
    input  logic                          res_ready,
    output blen_pkg::blen_res_t           res,
    output logic                          mem_we,
    output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
    output logic [blen_pkg::DATA_W-1:0]   mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  logic [blen_pkg::DATA_W-1:0]   mem_rdata
);
    import blen_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INS  = 4'd1;
    localparam logic [3:0] S_INSW = 4'd2;
    localparam logic [3:0] S_DRD  = 4'd3;
    localparam logic [3:0] S_DGET = 4'd4;
    localparam logic [3:0] S_DSH  = 4'd5;
    localparam logic [3:0] S_DSW  = 4'd6;
    localparam logic [3:0] S_TRD  = 4'd7;
    localparam logic [3:0] S_TCAP = 4'd8;
    localparam logic [3:0] S_SRD  = 4'd9;
    localparam logic [3:0] S_SCMP = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    blen_res_t         res_reg, res_next;

    logic [CW-1:0] ptr_dec, ptr_inc, cnt_inc, cnt_dec;
    logic [XW-1:0] pos_x, cnt_x, pos_m1;
    logic [CW-1:0] ins_idx, del_idx;
    logic          is_full, is_empty, pos_bad;

    function automatic logic [ENT_W-1:0] to_ent(input logic [CW-1:0] c);
        logic [XW-1:0] cx;
        cx = XW'(c);
        return cx[ENT_W-1:0];
    endfunction

    assign ptr_dec = ptr_reg - 1'b1;
    assign ptr_inc = ptr_reg + 1'b1;
    assign cnt_inc = count_reg + 1'b1;
    assign cnt_dec = count_reg - 1'b1;

    assign pos_x    = XW'(in_position);
    assign cnt_x    = XW'(count_reg);
    assign pos_m1   = pos_x - 1'b1;
    assign is_full  = (cnt_x == XW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    // position zero or past the tail cannot be deleted
    assign pos_bad  = (in_position == '0) || (pos_x > cnt_x);

    always_comb begin
        ins_idx = '0;
        if (in_mode == MODE_INS_END) begin
            ins_idx = count_reg;
        end else if (in_mode == MODE_INS_POS && in_position != '0) begin
            // past the end clamps to an append
            ins_idx = (pos_m1 > cnt_x) ? count_reg : CW'(pos_m1);
        end
    end

    always_comb begin
        del_idx = '0;
        if (in_mode == MODE_DEL_END) begin
            del_idx = cnt_dec;
        end else if (in_mode == MODE_DEL_POS) begin
            del_idx = CW'(pos_m1);
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    val_next         = in_value;
                    res_next.status  = STAT_OK;
                    res_next.data    = '0;
                    res_next.found   = 1'b0;
                    res_next.entries = to_ent(count_reg);
                    res_next.last    = 1'b1;
                    state_next       = S_EMIT;
                    unique case (in_mode)
                        MODE_INS_FRONT, MODE_INS_POS, MODE_INS_END: begin
                            if (is_full) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                idx_next   = ins_idx;
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_POS, MODE_DEL_END: begin
                            if (is_empty) begin
                                res_next.status = STAT_EMPTY;
                            end else if (in_mode == MODE_DEL_POS && pos_bad) begin
                                res_next.status = STAT_RANGE;
                            end else begin
                                idx_next   = del_idx;
                                state_next = S_DRD;
                            end
                        end
                        MODE_TRAVERSE: begin
                            if (is_empty) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                ptr_next   = cnt_dec;
                                state_next = S_TRD;
                            end
                        end
                        MODE_SEARCH: begin
                            if (is_empty) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                ptr_next   = '0;
                                state_next = S_SRD;
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                if (ptr_reg > idx_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_dec[AW-1:0];
                    state_next = S_INSW;
                end else begin
                    mem_we           = 1'b1;
                    mem_waddr        = idx_reg[AW-1:0];
                    mem_wdata        = val_reg;
                    count_next       = cnt_inc;
                    res_next.entries = to_ent(cnt_inc);
                    state_next       = S_EMIT;
                end
            end
            S_INSW: begin
                // move one element toward the tail
                mem_we     = 1'b1;
                ptr_next   = ptr_dec;
                state_next = S_INS;
            end
            S_DRD: begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_DGET;
            end
            S_DGET: begin
                res_next.data = mem_rdata;
                ptr_next      = idx_reg;
                state_next    = S_DSH;
            end
            S_DSH: begin
                if (ptr_inc < count_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[AW-1:0];
                    state_next = S_DSW;
                end else begin
                    count_next       = cnt_dec;
                    res_next.entries = to_ent(cnt_dec);
                    state_next       = S_EMIT;
                end
            end
            S_DSW: begin
                // move one element toward the head
                mem_we     = 1'b1;
                ptr_next   = ptr_inc;
                state_next = S_DSH;
            end
            S_TRD: begin
                mem_re     = 1'b1;
                state_next = S_TCAP;
            end
            S_TCAP: begin
                res_next.data = mem_rdata;
                res_next.last = (ptr_reg == '0);
                state_next    = S_EMIT;
            end
            S_SRD: begin
                mem_re     = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (mem_rdata == val_reg) begin
                    res_next.found = 1'b1;
                end
                if (ptr_inc == count_reg) begin
                    state_next = S_EMIT;
                end else begin
                    ptr_next   = ptr_inc;
                    state_next = S_SRD;
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    if (res_reg.last) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_dec;
                        state_next = S_TRD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)))
        else $error("element count moved by more than one");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result changed before it was taken");

    a_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr < CAPACITY))
        else $error("store write beyond capacity");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |=> (count_reg == $past(count_reg)))
        else $error("element count changed while idle");

endmodule

>>> design/bounded_ordered_list_engine_top.sv
// top level of the bounded ordered list engine
//
// keeps an ordered list of up to CAPACITY signed 32-bit values, head first.
// input beats (s_) carry an operation in s_tuser and value/position in s_tdata:
// insert front/position/end, delete front/position/end, traverse, search.
// every operation returns one result beat on m_; traverse returns one beat
// per element, tail first, with m_tlast on the final one (m_tlast is set on
// every single-beat result too).
// one element store is walked by a small sequencer, one element at a time:
//   insert  : moves each element from the insert index onward one place toward the tail
//   delete  : moves each element after the delete index one place toward the head
//   search  : reads and compares every element, head first
//   traverse: reads and sends one element at a time while m_tready stays high
// a full, empty or out-of-range case answers without touching the store. s_tready is high
// only between operations; the store port is the limit on all of these.
// results go through an output register, so the next beat can be taken while
// the final result of the previous one still waits. while m_tready is low the
// result beat holds and a traverse pauses.
// reset (aresetn low, synchronous) empties the list; store contents are not
// cleared, only entries below the count are ever read.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data[31:0], found[32], entries[37:33], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import blen_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              res_valid, res_ready;
    blen_res_t         res;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    // output register
    logic      m_valid_reg;
    blen_res_t m_res_reg;

    blen_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_position (s_tdata[DATA_W+POS_W-1:DATA_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    blen_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // take a new result whenever the output slot is empty or draining
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.entries, m_res_reg.found, m_res_reg.data};
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

endmodule

>>> bench/blen_list_checker.sv
// list predictor and result checker for the bounded ordered list engine
`timescale 1ns / 100ps

module blen_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]  s_tuser,   // mode[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // data[31:0], found[32], entries[37:33], zero pad
    input  logic [1:0]  m_tuser,   // status[1:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_cnt,
    output int          ops_seen,
    output int          results_seen,
    output int          peak_depth,
    output int          full_seen,
    output int          empty_seen,
    output int          range_seen
);
    import blen_pkg::*;

    logic signed [DATA_W-1:0] shadow_list[$];     // head at index 0
    blen_res_t                pending_results[$]; // oldest first

    function automatic void queue_result(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] d,
                                         logic f, logic l);
        blen_res_t r;
        r.status  = st;
        r.data    = d;
        r.found   = f;
        r.entries = ENT_W'(shadow_list.size());
        r.last    = l;
        pending_results.insert(pending_results.size(), r);
        if (st == STAT_FULL)  full_seen++;
        if (st == STAT_EMPTY) empty_seen++;
        if (st == STAT_RANGE) range_seen++;
    endfunction

    // one operation on the shadow list, with the beats it must produce
    function automatic void apply_list_op(logic [MODE_W-1:0] op, logic signed [DATA_W-1:0] v,
                                          logic [POS_W-1:0] p);
        int  n;
        int  idx;
        logic hit;
        logic signed [DATA_W-1:0] d;
        n = shadow_list.size();
        case (op)
            MODE_INS_FRONT, MODE_INS_POS, MODE_INS_END: begin
                if (n >= CAPACITY) begin
                    queue_result(STAT_FULL, '0, 1'b0, 1'b1);
                end else begin
                    if (op == MODE_INS_FRONT)    idx = 0;
                    else if (op == MODE_INS_END) idx = n;
                    else                         idx = (p == 0) ? 0 : int'(p) - 1;
                    if (idx > n) idx = n;   // past the end appends
                    shadow_list.insert(idx, v);
                    queue_result(STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            MODE_DEL_FRONT, MODE_DEL_POS, MODE_DEL_END: begin
                if (n == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b0, 1'b1);
                end else if (op == MODE_DEL_POS && (p == 0 || int'(p) > n)) begin
                    queue_result(STAT_RANGE, '0, 1'b0, 1'b1);
                end else begin
                    if (op == MODE_DEL_FRONT)    idx = 0;
                    else if (op == MODE_DEL_END) idx = n - 1;
                    else                         idx = int'(p) - 1;
                    d = shadow_list[idx];
                    shadow_list.delete(idx);
                    queue_result(STAT_OK, d, 1'b0, 1'b1);
                end
            end
            MODE_TRAVERSE: begin
                if (n == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    // tail first, last beat on the head
                    for (int i = 0; i < n; i++)
                        queue_result(STAT_OK, shadow_list[n - 1 - i], 1'b0, i == n - 1);
                end
            end
            default: begin
                if (n == 0) begin
                    queue_result(STAT_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    hit = 1'b0;
                    foreach (shadow_list[i])
                        if (shadow_list[i] == v) hit = 1'b1;
                    queue_result(STAT_OK, '0, hit, 1'b1);
                end
            end
        endcase
        if (shadow_list.size() > peak_depth) peak_depth = shadow_list.size();
    endfunction

    function automatic string show_result(blen_res_t r);
        return $sformatf("status %0d data %0d found %0b entries %0d last %0b",
                         r.status, r.data, r.found, r.entries, r.last);
    endfunction

    always @(posedge aclk) begin : watch
        blen_res_t seen;
        blen_res_t want;
        if (!aresetn) begin
            shadow_list.delete();
            pending_results.delete();
            fail_count   = 0;
            ops_seen     = 0;
            results_seen = 0;
            peak_depth   = 0;
            full_seen    = 0;
            empty_seen   = 0;
            range_seen   = 0;
        end else begin
            // results first: a beat taken at this edge is never from this edge's input
            if (m_tvalid && m_tready) begin
                seen.status  = m_tuser;
                seen.data    = m_tdata[31:0];
                seen.found   = m_tdata[32];
                seen.entries = m_tdata[37:33];
                seen.last    = m_tlast;
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: expected none, got %s",
                             $realtime, show_result(seen));
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        $display("%0t: result %0d mismatch: expected %s, got %s",
                                 $realtime, results_seen, show_result(want), show_result(seen));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ops_seen++;
                apply_list_op(s_tuser, s_tdata[31:0], s_tdata[36:32]);
            end
        end
        pending_cnt = pending_results.size();
    end

endmodule

>>> bench/bounded_ordered_list_engine_top_tb.sv
// stimulus and verdict for the bounded ordered list engine
`timescale 1ns / 100ps

module bounded_ordered_list_engine_top_tb;
    import blen_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RANDOM_OPS  = 140;
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off
    localparam int SETTLE      = 60;
    localparam int LIMIT       = 200000;   // generous cap on the whole run

    typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED, RUN_PROBE} run_kind_t;

    // every block input starts at a known value
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], position[36:32], zero pad
    logic [2:0]  s_tuser  = '0;   // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // data[31:0], found[32], entries[37:33], zero pad
    logic [1:0]  m_tuser;         // status[1:0]
    logic        m_tlast;

    int fail_count, pending_cnt, ops_seen, results_seen;
    int peak_depth, full_seen, empty_seen, range_seen;

    // shared control between the sender and the receiver
    bit calm     = 1'b0;   // no idling on either side while set
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off

    int random_sent = 0;
    logic signed [DATA_W-1:0] used_keys[$];   // recent insert values, reused as search keys

    bounded_ordered_list_engine_top #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    blen_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending_cnt  (pending_cnt),
        .ops_seen     (ops_seen),
        .results_seen (results_seen),
        .peak_depth   (peak_depth),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen),
        .range_seen   (range_seen)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one beat and return at the edge that takes it; valid stays up so a
    // following beat can go out back to back without a low/high glitch
    task automatic offer_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] v,
                            input logic [POS_W-1:0] p);
        // random idle gaps; each further idle step has a one-in-five chance
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, p, v};
        s_tuser  <= op;
        // inputs sampled right after the edge still hold their pre-edge values
        do @(posedge aclk); while (!s_tready);
        if (op == MODE_INS_FRONT || op == MODE_INS_POS || op == MODE_INS_END) begin
            used_keys.insert(used_keys.size(), v);
            if (used_keys.size() > 64) void'(used_keys.pop_front());
        end
    endtask

    // sender stands still until every predicted beat has come back
    task automatic wait_list_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_cnt != 0) @(posedge aclk);
    endtask

    // a run of random beats shaped by kind: fills push the list to full,
    // drains empty it, probes walk and search it, mixed is anything
    task automatic run_ops(input run_kind_t kind, input int len);
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         p;
        for (int i = 0; i < len; i++) begin
            case (kind)
                RUN_FILL:  op = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_INS_END));
                RUN_DRAIN: op = MODE_W'($urandom_range(MODE_DEL_FRONT, MODE_DEL_END));
                RUN_PROBE: op = $urandom_range(0, 1) ? MODE_TRAVERSE : MODE_SEARCH;
                default:   op = MODE_W'($urandom_range(MODE_INS_FRONT, MODE_SEARCH));
            endcase
            // extremes now and then, recent keys so searches can hit
            case ($urandom_range(0, 9))
                0:       v = 32'sh7fff_ffff;
                1:       v = 32'sh8000_0000;
                2, 3:    v = (used_keys.size() != 0) ?
                             used_keys[$urandom_range(0, used_keys.size() - 1)] : $urandom;
                default: v = $urandom;
            endcase
            // mostly meaningful positions, sometimes the whole 5-bit range
            if ($urandom_range(0, 4) == 0) p = POS_W'($urandom_range(0, 31));
            else                           p = POS_W'($urandom_range(1, 17));
            offer_op(op, v, p);
        end
        random_sent += len;
    endtask

    // receiver: random stalls, a calm stretch, and one long hold-off counted here
    initial begin : result_side
        bit held;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                held = 1'b1;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
            @(posedge aclk);
        end
    end

    // run-length cap
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d result beats still outstanding",
                 cycles, pending_cnt);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : op_side
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: traverse, search and every delete on an empty list
        offer_op(MODE_TRAVERSE,  32'sd0, 5'd1);
        offer_op(MODE_SEARCH,    32'sd5, 5'd1);
        offer_op(MODE_DEL_FRONT, 32'sd0, 5'd1);
        offer_op(MODE_DEL_POS,   32'sd0, 5'd1);
        offer_op(MODE_DEL_END,   32'sd0, 5'd1);
        // first insert lands at the front; value extremes
        offer_op(MODE_INS_FRONT, 32'sh7fff_ffff, 5'd1);
        offer_op(MODE_INS_END,   32'sh8000_0000, 5'd1);
        // position zero goes first, a position past the end appends
        offer_op(MODE_INS_POS,   -32'sd1, 5'd0);
        offer_op(MODE_INS_POS,   32'sd0, 5'd31);
        offer_op(MODE_INS_POS,   32'sd1, 5'd2);
        // search hit and miss
        offer_op(MODE_SEARCH,    32'sh8000_0000, 5'd1);
        offer_op(MODE_SEARCH,    32'sd12345, 5'd1);
        // delete at position zero and past the end, then at the very end
        offer_op(MODE_DEL_POS,   32'sd0, 5'd0);
        offer_op(MODE_DEL_POS,   32'sd0, 5'd31);
        offer_op(MODE_DEL_POS,   32'sd0, 5'd5);
        offer_op(MODE_TRAVERSE,  32'sd0, 5'd1);

        // random: fill to full and knock on it
        run_ops(RUN_FILL, 20);

        // long receiver hold while a full traverse and more beats queue up,
        // so the block backs up and drops s_tready
        hold_req = 1'b1;
        offer_op(MODE_TRAVERSE, 32'sd0, 5'd1);
        run_ops(RUN_PROBE, 6);
        wait_list_drained();

        // empty it again, past the bottom
        run_ops(RUN_DRAIN, 20);

        // stretch with no idling on either side
        calm = 1'b1;
        run_ops(RUN_MIXED, 30);
        calm = 1'b0;

        while (random_sent < RANDOM_OPS) begin
            case ($urandom_range(0, 3))
                0:       run_ops(RUN_FILL,  $urandom_range(6, 20));
                1:       run_ops(RUN_DRAIN, $urandom_range(6, 20));
                2:       run_ops(RUN_PROBE, $urandom_range(3, 8));
                default: run_ops(RUN_MIXED, $urandom_range(5, 15));
            endcase
        end

        wait_list_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d operations of all eight kinds, %0d result beats,",
                 ops_seen, results_seen);
        $display("list depth up to %0d; answers seen: %0d full, %0d empty, %0d out of range",
                 peak_depth, full_seen, empty_seen, range_seen);
        if (fail_count == 0 && pending_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
